// ===== rtl/isr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isr_pkg
// Shared widths, register map and the single digit step of the restoring
// square root used by the integer and active fraction stages.
// ---------------------------------------------------------------------------
package isr_pkg;

   localparam int RADICAND_WIDTH_DEFAULT = 32;
   localparam int INPUT_WIDTH            = 32;
   localparam int ROOT_WIDTH             = 31;
   localparam int REM_WIDTH              = 32;
   localparam int FRACTION_WIDTH         = 4;
   localparam int MAX_FRACTION           = (1 << FRACTION_WIDTH) - 1;
   localparam int CSR_ADDR_WIDTH         = 3;
   localparam int CSR_DATA_WIDTH         = 32;
   localparam int RSP_DATA_WIDTH         = 32;

   localparam logic [FRACTION_WIDTH-1:0] FRACTION_RESET = 4'd6;

   // register index, taken from the word address bits of paddr
   localparam logic [CSR_ADDR_WIDTH-3:0] CSR_FRACTION_BITS = 1'b0;

   typedef struct packed {
      logic [ROOT_WIDTH-1:0] root;
      logic [REM_WIDTH-1:0]  rem;
   } step_type;

   // one restoring step: shift a bit pair into the remainder, try 4*root+1
   function automatic step_type root_step(input step_type cur, input logic [1:0] pair);
      logic [REM_WIDTH-1:0] shifted;
      logic [REM_WIDTH-1:0] trial;
      logic [REM_WIDTH-1:0] diff;
      step_type             nxt;
      shifted = {cur.rem[REM_WIDTH-3:0], pair};
      trial   = {cur.root[REM_WIDTH-3:0], 2'b01};
      diff    = shifted - trial;
      if (diff[REM_WIDTH-1]) begin
         nxt.rem  = shifted;
         nxt.root = {cur.root[ROOT_WIDTH-2:0], 1'b0};
      end else begin
         nxt.rem  = diff;
         nxt.root = {cur.root[ROOT_WIDTH-2:0], 1'b1};
      end
      return nxt;
   endfunction

endpackage

// ===== rtl/integer_square_root_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// integer_square_root_unit
// Pipelined restoring digit-by-digit square root with configurable
// fraction bits.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one unsigned radicand per item (low RADICAND_WIDTH bits
//   used). rsp_* returns floor(sqrt(radicand) * 2^fraction_bits) in 31 bits.
//   fraction_bits (0..15, reset 6) sits at csr byte address 0.
// Stages and throughput:
//   one stage per digit step: (RADICAND_WIDTH+1)/2 integer steps followed by
//   15 fraction steps, of which stages past fraction_bits just pass the item
//   on. One item per cycle is taken, limited only by the output.
// Reset:
//   clears all stage valid bits and loads fraction_bits with 6.
// Stalls:
//   each stage moves when it is empty or the next one moves, so bubbles
//   close up and items enter while a result waits, until all stages are full.
// ---------------------------------------------------------------------------
module integer_square_root_unit #(
   parameter int RADICAND_WIDTH = isr_pkg::RADICAND_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // radicand [31:0]
   input  logic [isr_pkg::INPUT_WIDTH-1:0]     req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // root [30:0], bit 31 zero
   output logic [isr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [isr_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [isr_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [isr_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import isr_pkg::*;

   localparam int PAIR_COUNT  = (RADICAND_WIDTH + 1) / 2;
   localparam int EVEN_WIDTH  = 2 * PAIR_COUNT;
   localparam int STAGE_COUNT = PAIR_COUNT + MAX_FRACTION;

   logic [FRACTION_WIDTH-1:0] fraction_ff;
   logic                      csr_hit;

   logic [EVEN_WIDTH-1:0]     data_ff  [STAGE_COUNT];
   step_type                  state_ff [STAGE_COUNT];
   logic [STAGE_COUNT-1:0]    valid_ff;

   logic [EVEN_WIDTH-1:0]     data_in  [STAGE_COUNT];
   step_type                  state_in [STAGE_COUNT];
   logic [STAGE_COUNT-1:0]    valid_in;
   logic [STAGE_COUNT:0]      advance;

   // configuration port
   assign csr_hit    = (csr_paddr[CSR_ADDR_WIDTH-1:2] == CSR_FRACTION_BITS);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? CSR_DATA_WIDTH'(fraction_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fraction_ff <= FRACTION_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         fraction_ff <= csr_pwdata[FRACTION_WIDTH-1:0];
      end
   end

   // a stage moves when it is empty or its successor moves,
   // worked out from the output end back
   always_comb begin
      advance[STAGE_COUNT] = rsp_tready;
      for (int k = STAGE_COUNT - 1; k >= 0; k--) begin
         advance[k] = !valid_ff[k] || advance[k+1];
      end
   end

   assign req_tready = advance[0];
   assign rsp_tvalid = valid_ff[STAGE_COUNT-1];
   assign rsp_tdata  = RSP_DATA_WIDTH'(state_ff[STAGE_COUNT-1].root);

   for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_stage
      logic [EVEN_WIDTH-1:0] prev_data;
      step_type              prev_state;
      logic                  prev_valid;

      if (k == 0) begin : g_first
         assign prev_data  = EVEN_WIDTH'(req_tdata[RADICAND_WIDTH-1:0]);
         assign prev_state = '0;
         assign prev_valid = req_tvalid;
      end else begin : g_next
         assign prev_data  = data_ff[k-1];
         assign prev_state = state_ff[k-1];
         assign prev_valid = valid_ff[k-1];
      end

      always_comb begin
         data_in[k]  = prev_data;
         valid_in[k] = prev_valid;
         if (k < PAIR_COUNT) begin
            state_in[k] = root_step(prev_state, prev_data[EVEN_WIDTH-1-2*(k % PAIR_COUNT) -: 2]);
         end else if (FRACTION_WIDTH'(k - PAIR_COUNT) < fraction_ff) begin
            state_in[k] = root_step(prev_state, 2'b00);
         end else begin
            // fraction step not in use, item passes unchanged
            state_in[k] = prev_state;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance[k]) begin
            valid_ff[k] <= valid_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance[k]) begin
            data_ff[k]  <= data_in[k];
            state_ff[k] <= state_in[k];
         end
      end
   end

endmodule
